FILE: hdl/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// shared constants and types for the length-type-value stream deframer
// ----------------------------------------------------------------------------
package tlvd_pkg;

   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned BYTE_W    = 8;

   // one result as produced by the parser for the current request
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] message_type;
      logic [WORD_W-1:0] message_length;
      logic [BYTE_W-1:0] payload_byte;
      logic              has_byte;
      logic              first_of_message;
      logic              last_of_message;
   } result_type;

endpackage

FILE: hdl/tlvd_parser.sv
// ----------------------------------------------------------------------------
// tlvd_parser
// header collection and payload tracking, one byte per accepted request
// ----------------------------------------------------------------------------
module tlvd_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [tlvd_pkg::BYTE_W-1:0]          data_byte,
   output tlvd_pkg::result_type                 result
);

   logic [tlvd_pkg::CNT_W-1:0]  header_count_ff, header_count_in;
   logic [tlvd_pkg::WORD_W-1:0] length_ff, length_in;
   logic [tlvd_pkg::WORD_W-1:0] type_ff, type_in;
   logic [tlvd_pkg::WORD_W-1:0] remaining_ff, remaining_in;
   logic [tlvd_pkg::WORD_W-1:0] remaining_dec;
   logic [1:0]                  pos;
   logic                        in_header;
   logic [tlvd_pkg::CNT_W-1:0]  count_inc;

   assign in_header     = header_count_ff < tlvd_pkg::CNT_W'(tlvd_pkg::HDR_BYTES);
   assign pos           = header_count_ff[1:0];
   assign count_inc     = header_count_ff + tlvd_pkg::CNT_W'(1);
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - tlvd_pkg::WORD_W'(1)
                                               : remaining_ff;

   always_comb begin
      header_count_in = header_count_ff;
      length_in       = length_ff;
      type_in         = type_ff;
      remaining_in    = remaining_ff;

      result                  = '0;
      result.message_type     = type_ff;
      result.message_length   = length_ff;

      if (in_header) begin
         // little-endian byte lanes: length first, then type
         for (int i = 0; i < 4; i++) begin
            if (pos == 2'(i)) begin
               if (!header_count_ff[2]) begin
                  length_in[i*tlvd_pkg::BYTE_W +: tlvd_pkg::BYTE_W] = data_byte;
               end else begin
                  type_in[i*tlvd_pkg::BYTE_W +: tlvd_pkg::BYTE_W] = data_byte;
               end
            end
         end
         header_count_in = count_inc;
         if (count_inc == tlvd_pkg::CNT_W'(tlvd_pkg::HDR_BYTES)) begin
            if (length_in == '0) begin
               // empty message: one result with no byte
               result.valid            = 1'b1;
               result.message_type     = type_in;
               result.message_length   = length_in;
               result.first_of_message = 1'b1;
               result.last_of_message  = 1'b1;
               header_count_in         = '0;
            end else begin
               remaining_in = length_in;
            end
         end
      end else begin
         result.valid            = 1'b1;
         result.payload_byte     = data_byte;
         result.has_byte         = 1'b1;
         result.first_of_message = remaining_ff == length_ff;
         result.last_of_message  = remaining_ff <= tlvd_pkg::WORD_W'(1);
         remaining_in            = remaining_dec;
         header_count_in         = (remaining_dec == '0) ? '0
                                   : tlvd_pkg::CNT_W'(tlvd_pkg::HDR_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         length_ff       <= '0;
         type_ff         <= '0;
         remaining_ff    <= '0;
      end else if (accept) begin
         header_count_ff <= header_count_in;
         length_ff       <= length_in;
         type_ff         <= type_in;
         remaining_ff    <= remaining_in;
      end
   end

endmodule

FILE: hdl/tlv_stream_deframer_core.sv
// ----------------------------------------------------------------------------
// tlv_stream_deframer_core
// length-type-value deframer for a byte stream, 32-bit little-endian header
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_data_byte) takes one raw
// stream byte per accepted request. Eight header bytes (length, then type,
// both little-endian) give no response; each following payload byte gives one
// response on the rsp_ channel, tagged with type, length and first/last
// marks. A header whose length is zero gives a single response with
// rsp_has_byte low and both marks set.
// A response appears in the output register on the cycle after its request
// is accepted. Throughput is one byte per cycle while the receiver does not
// stall, set by the single parser step between request and output register.
// When the receiver stalls while a response is held, req_stall is raised
// and the held response stays unchanged; otherwise requests keep flowing.
// Synchronous reset clears the header counter, the length, type and
// remaining-byte registers and the output valid; the block then expects
// the first header byte.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tlvd_pkg::BYTE_W-1:0]         req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tlvd_pkg::WORD_W-1:0]         rsp_message_type,
   output logic [tlvd_pkg::WORD_W-1:0]         rsp_message_length,
   output logic [tlvd_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                                rsp_has_byte,
   output logic                                rsp_first_of_message,
   output logic                                rsp_last_of_message
);

   tlvd_pkg::result_type result;
   tlvd_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;
   logic                 out_free;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !out_free;
   assign req_accept = req_valid && out_free;

   tlvd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .result    (result)
   );

   assign rsp_valid_in = out_free ? (req_accept && result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register loads only when a new response is taken
   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_message_type     = rsp_ff.message_type;
   assign rsp_message_length   = rsp_ff.message_length;
   assign rsp_payload_byte     = rsp_ff.payload_byte;
   assign rsp_has_byte         = rsp_ff.has_byte;
   assign rsp_first_of_message = rsp_ff.first_of_message;
   assign rsp_last_of_message  = rsp_ff.last_of_message;

`ifndef SYNTHESIS
   // an empty message is always a single, complete response
   a_empty_msg : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.has_byte |-> rsp_ff.first_of_message
                                           && rsp_ff.last_of_message
                                           && rsp_ff.message_length == '0
                                           && rsp_ff.payload_byte == '0)
      else $error("empty message response malformed");

   // back-pressure only while a response is held
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled without a held response");

   // a payload byte of a message with length one is both first and last
   a_len_one : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_byte && rsp_ff.message_length == 32'd1
         |-> rsp_ff.first_of_message && rsp_ff.last_of_message)
      else $error("single-byte message not marked first and last");

   // output register empty straight after reset
   a_reset_clear : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the length-type-value stream deframer. A model of the deframer
// built into the testbench turns every accepted byte request into the
// responses it should cause. Each accepted response is checked field by field
// against the oldest one still waiting. A short directed opening comes first:
// an empty message with an all-ones type, and a one-byte message. Random
// messages of mostly short and a few long lengths follow, with random gaps on
// the request side and random stalls on the response side. The run ends on a
// message with the largest length, only partly streamed.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // tracks header and payload phases exactly as the deframer should
   class tlv_frame_predictor_type;
      logic [tlvd_pkg::CNT_W-1:0]  hdr_count;
      logic [tlvd_pkg::WORD_W-1:0] length_word;
      logic [tlvd_pkg::WORD_W-1:0] type_word;
      logic [tlvd_pkg::WORD_W-1:0] bytes_left;
      tlvd_pkg::result_type        expected_beats[$];
      int unsigned                 mismatch_count;

      function new();
         hdr_count      = '0;
         length_word    = '0;
         type_word      = '0;
         bytes_left     = '0;
         mismatch_count = 0;
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction

      function void push_beat(logic [tlvd_pkg::BYTE_W-1:0] b, logic has,
                              logic first_flag, logic last_flag);
         tlvd_pkg::result_type beat;
         beat.valid            = 1'b1;
         beat.message_type     = type_word;
         beat.message_length   = length_word;
         beat.payload_byte     = b;
         beat.has_byte         = has;
         beat.first_of_message = first_flag;
         beat.last_of_message  = last_flag;
         expected_beats = {expected_beats, beat};
      endfunction

      function void note_request(logic [tlvd_pkg::BYTE_W-1:0] b);
         logic [1:0] pos;
         logic       first_flag;
         logic       last_flag;
         if (hdr_count < tlvd_pkg::HDR_BYTES) begin
            pos = hdr_count[1:0];
            if (hdr_count < 4)
               length_word[pos*8 +: 8] = b;
            else
               type_word[pos*8 +: 8] = b;
            hdr_count = hdr_count + 1'b1;
            if (hdr_count == tlvd_pkg::HDR_BYTES) begin
               if (length_word == '0) begin
                  // empty message: single response without a byte
                  push_beat('0, 1'b0, 1'b1, 1'b1);
                  hdr_count = '0;
               end else begin
                  bytes_left = length_word;
               end
            end
         end else begin
            first_flag = (bytes_left == length_word);
            last_flag  = (bytes_left <= 1);
            push_beat(b, 1'b1, first_flag, last_flag);
            if (bytes_left != '0)
               bytes_left = bytes_left - 1'b1;
            hdr_count = (bytes_left == '0) ? '0
                        : tlvd_pkg::CNT_W'(tlvd_pkg::HDR_BYTES);
         end
      endfunction

      function void check_response(tlvd_pkg::result_type got);
         tlvd_pkg::result_type exp_beat;
         if (expected_beats.size() == 0) begin
            $error("response with no request waiting for it");
            mismatch_count++;
            return;
         end
         exp_beat = expected_beats.pop_front();
         if (got.message_type !== exp_beat.message_type) begin
            $error("message_type expected %h actual %h",
                   exp_beat.message_type, got.message_type);
            mismatch_count++;
         end
         if (got.message_length !== exp_beat.message_length) begin
            $error("message_length expected %h actual %h",
                   exp_beat.message_length, got.message_length);
            mismatch_count++;
         end
         if (got.payload_byte !== exp_beat.payload_byte) begin
            $error("payload_byte expected %h actual %h",
                   exp_beat.payload_byte, got.payload_byte);
            mismatch_count++;
         end
         if (got.has_byte !== exp_beat.has_byte) begin
            $error("has_byte expected %b actual %b", exp_beat.has_byte, got.has_byte);
            mismatch_count++;
         end
         if (got.first_of_message !== exp_beat.first_of_message) begin
            $error("first_of_message expected %b actual %b",
                   exp_beat.first_of_message, got.first_of_message);
            mismatch_count++;
         end
         if (got.last_of_message !== exp_beat.last_of_message) begin
            $error("last_of_message expected %b actual %b",
                   exp_beat.last_of_message, got.last_of_message);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [tlvd_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [tlvd_pkg::WORD_W-1:0]   rsp_message_type;
   logic [tlvd_pkg::WORD_W-1:0]   rsp_message_length;
   logic [tlvd_pkg::BYTE_W-1:0]   rsp_payload_byte;
   logic                          rsp_has_byte;
   logic                          rsp_first_of_message;
   logic                          rsp_last_of_message;

   tlv_frame_predictor_type  frames = new();
   int unsigned         bytes_sent = 0;
   bit                  tx_calm    = 1'b0;
   bit                  rx_calm    = 1'b0;
   int                  stall_run  = 0;
   int                  rx_mode_left = 0;

   tlv_stream_deframer_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_message_type     (rsp_message_type),
      .rsp_message_length   (rsp_message_length),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_has_byte         (rsp_has_byte),
      .rsp_first_of_message (rsp_first_of_message),
      .rsp_last_of_message  (rsp_last_of_message)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short idle runs, now and then a long one
   function automatic int pick_idle(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [tlvd_pkg::BYTE_W-1:0] b);
      int gap;
      gap = pick_idle(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames.note_request(b);
      bytes_sent++;
   endtask

   task automatic send_message(input logic [tlvd_pkg::WORD_W-1:0] msg_len,
                               input logic [tlvd_pkg::WORD_W-1:0] frame_type,
                               input int unsigned body_bytes);
      for (int i = 0; i < 4; i++)
         send_byte(msg_len[8*i +: 8]);
      for (int i = 0; i < 4; i++)
         send_byte(frame_type[8*i +: 8]);
      for (int unsigned i = 0; i < body_bytes; i++)
         send_byte(tlvd_pkg::BYTE_W'($urandom_range(0, 255)));
   endtask

   // hold off requests until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames.outstanding() != 0);
   endtask

   // response side: check, then choose the stall for the next cycle
   always @(posedge clock) begin
      tlvd_pkg::result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.valid            = 1'b1;
            got.message_type     = rsp_message_type;
            got.message_length   = rsp_message_length;
            got.payload_byte     = rsp_payload_byte;
            got.has_byte         = rsp_has_byte;
            got.first_of_message = rsp_first_of_message;
            got.last_of_message  = rsp_last_of_message;
            frames.check_response(got);
         end
         if (rx_mode_left == 0) begin
            rx_calm      = ($urandom_range(0, 2) == 0);
            rx_mode_left = $urandom_range(50, 300);
         end else begin
            rx_mode_left--;
         end
         if (stall_run == 0)
            stall_run = pick_idle(rx_calm);
         if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [tlvd_pkg::WORD_W-1:0] msg_len;
      int                          r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message with all-ones type, then a one-byte message
      tx_calm = 1'b1;
      send_message('0, '1, 0);
      send_message(32'd1, '0, 0);
      send_byte(8'hFF);
      wait_drained();

      while (bytes_sent < 1100) begin
         tx_calm = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 50)
            msg_len = $urandom_range(0, 4);
         else if (r < 80)
            msg_len = $urandom_range(5, 20);
         else if (r < 95)
            msg_len = $urandom_range(21, 64);
         else
            msg_len = $urandom_range(65, 300);
         send_message(msg_len, tlvd_pkg::WORD_W'($urandom), msg_len);
         if ($urandom_range(0, 29) == 0)
            wait_drained();
      end

      // largest length: only the start of the payload is streamed
      send_message('1, tlvd_pkg::WORD_W'($urandom), 40);

      req_valid <= 1'b0;
      do @(posedge clock); while (frames.outstanding() != 0);
      repeat (4) @(posedge clock);
      if (frames.mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
